FILE: design/schc_pkg.sv
// ----------------------------------------------------------------------------
// schc_pkg: shared types and constants of the ICMPv6 echo decompressor
// Status codes, back-end phases, queue entry and header snapshot layouts,
// and the ones' complement add used by the checksum logic.
// ----------------------------------------------------------------------------
package schc_pkg;

  // Packet limits and residue layout
  localparam logic [15:0] MAX_PACKET_BYTES = 16'd1280;
  localparam logic [15:0] CAP_RESET        = 16'd1280;
  localparam logic [15:0] RES_LAST_BYTE    = 16'd22;
  localparam logic [15:0] HDR_BYTES        = 16'd48;
  localparam logic [16:0] MIN_PACKET       = 17'd23;
  localparam logic [16:0] HDR_OVERHEAD     = 17'd25;
  localparam logic [15:0] ICMP_ADJUST      = 16'd15;
  localparam logic [7:0]  ECHO_REQUEST     = 8'd128;
  localparam logic [7:0]  ECHO_REPLY       = 8'd129;
  localparam logic [5:0]  HDR_LAST_IDX     = 6'd47;
  localparam logic [5:0]  FIN_LAST_IDX     = 6'd3;

  // Pseudo-header constants pre-summed: fe80 (src) + fe80 (dst) + next header 58
  localparam logic [15:0] CK_INIT = 16'hFD3B;

  // Output offsets of the patched fields
  localparam logic [15:0] OFF_LEN_HI = 16'd4;
  localparam logic [15:0] OFF_LEN_LO = 16'd5;
  localparam logic [15:0] OFF_CK_HI  = 16'd42;
  localparam logic [15:0] OFF_CK_LO  = 16'd43;

  // Queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // Config port
  localparam int unsigned CFG_AW = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BAD_TYPE = 2'd2,
    ST_TOO_BIG  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HDR = 2'd0,
    PH_PAY = 2'd1,
    PH_FIN = 2'd2
  } phase_t;

  // Header fields captured at the end of the residue
  typedef struct packed {
    logic [7:0]  hop;
    logic [63:0] src;
    logic [63:0] dst;
    logic [7:0]  etype;
    logic [15:0] ident;
    logic [15:0] seq;
  } hdr_t;

  // Work for the back end caused by one input item
  typedef struct packed {
    logic        do_hdr;
    logic        do_pay;
    logic [15:0] pay_off;
    logic [7:0]  pay_byte;
    logic        do_fin;
    logic        fin_ok;
    status_t     fin_status;
    logic [15:0] fin_len;
    logic [15:0] fin_ck;
  } q_entry_t;

  // Ones' complement 16-bit add with end-around carry
  function automatic logic [15:0] add16(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

FILE: design/schc_fifo.sv
// ----------------------------------------------------------------------------
// schc_fifo: work queue between front and back end
// Small register queue of q_entry_t; head is shown combinationally.
// ----------------------------------------------------------------------------
module schc_fifo import schc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_ent,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty,
  output logic     full
);

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(push);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    cnt_nxt    = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));

endmodule

FILE: design/schc_front.sv
// ----------------------------------------------------------------------------
// schc_front: byte intake and classification
// Counts bytes, collects the residue, keeps the running checksum and error,
// and queues header, payload and final work for the back end.
// ----------------------------------------------------------------------------
module schc_front import schc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic [15:0] out_capacity,
  input  logic        q_full,
  input  logic        hdr_release,
  output logic        push,
  output q_entry_t    push_ent,
  output hdr_t        hdr
);

  logic [15:0] bc_r, bc_nxt;
  logic [7:0]  hop_r, hop_nxt;
  logic [63:0] src_r, src_nxt;
  logic [63:0] dst_r, dst_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] sum_r, sum_nxt;
  status_t     err_r, err_nxt;
  hdr_t        hdr_r, hdr_nxt;
  logic        hdr_full_r, hdr_full_nxt;

  logic        acc;
  logic [7:0]  d;
  status_t     err_a, err_b, st;
  logic        type_ok, do_hdr, do_pay, in_residue, hi_byte;
  logic [16:0] off17, len17;
  logic [15:0] word, sum_v, echo_len, ck;

  // header snapshot stays busy until the back end has sent it
  assign in_tready = !q_full && !((bc_r == RES_LAST_BYTE) && hdr_full_r);
  assign acc       = in_tvalid && in_tready;
  assign d         = in_tdata;
  assign hdr       = hdr_r;

  // classification of the current byte
  always_comb begin
    err_a   = (bc_r >= MAX_PACKET_BYTES) ? ST_TOO_BIG : err_r;
    type_ok = (type_r == ECHO_REQUEST) || (type_r == ECHO_REPLY);
    off17   = {1'b0, bc_r} + HDR_OVERHEAD;
    do_hdr  = 1'b0;
    do_pay  = 1'b0;
    err_b   = err_a;
    if ((bc_r == RES_LAST_BYTE) && (err_a == ST_OK)) begin
      if (!type_ok) begin
        err_b = ST_BAD_TYPE;
      end else if (out_capacity < HDR_BYTES) begin
        err_b = ST_TOO_BIG;
      end else begin
        do_hdr = 1'b1;
      end
    end else if ((bc_r > RES_LAST_BYTE) && (err_a == ST_OK)) begin
      if (off17 >= {1'b0, out_capacity}) begin
        err_b = ST_TOO_BIG;
      end else begin
        do_pay = 1'b1;
      end
    end
  end

  // running checksum: residue words from byte 2 on, then written payload
  always_comb begin
    in_residue = (bc_r >= 16'd2) && (bc_r <= RES_LAST_BYTE);
    // even bytes are high halves up to the echo type, odd ones after it
    hi_byte    = (bc_r <= 16'd18) ? !bc_r[0] : bc_r[0];
    word       = hi_byte ? {d, 8'd0} : {8'd0, d};
    sum_v      = (in_residue || do_pay) ? add16(sum_r, word) : sum_r;
  end

  // final status and patch values
  always_comb begin
    len17    = {1'b0, bc_r} + 17'd1;
    st       = err_b;
    if (st == ST_OK) begin
      if (len17 < MIN_PACKET) begin
        st = ST_SHORT;
      end else if ((len17 + HDR_OVERHEAD) > {1'b0, out_capacity}) begin
        st = ST_TOO_BIG;
      end
    end
    echo_len = len17[15:0] - ICMP_ADJUST;
    ck       = ~add16(sum_v, echo_len);
  end

  // queue entry
  always_comb begin
    push                = acc && (do_hdr || do_pay || in_tlast);
    push_ent.do_hdr     = do_hdr;
    push_ent.do_pay     = do_pay;
    push_ent.pay_off    = off17[15:0];
    push_ent.pay_byte   = d;
    push_ent.do_fin     = in_tlast;
    push_ent.fin_ok     = (st == ST_OK);
    push_ent.fin_status = st;
    push_ent.fin_len    = echo_len;
    push_ent.fin_ck     = ck;
  end

  // next packet state
  always_comb begin
    bc_nxt       = bc_r;
    hop_nxt      = hop_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    type_nxt     = type_r;
    id_nxt       = id_r;
    seq_nxt      = seq_r;
    sum_nxt      = sum_r;
    err_nxt      = err_r;
    hdr_nxt      = hdr_r;
    hdr_full_nxt = hdr_full_r && !hdr_release;
    if (acc) begin
      bc_nxt  = (bc_r == 16'hFFFF) ? bc_r : bc_r + 16'd1;
      sum_nxt = sum_v;
      err_nxt = err_b;
      if (bc_r == 16'd1) begin
        hop_nxt = d;
      end else if ((bc_r >= 16'd2) && (bc_r <= 16'd9)) begin
        src_nxt = {src_r[55:0], d};
      end else if ((bc_r >= 16'd10) && (bc_r <= 16'd17)) begin
        dst_nxt = {dst_r[55:0], d};
      end else if (bc_r == 16'd18) begin
        type_nxt = d;
      end else if ((bc_r == 16'd19) || (bc_r == 16'd20)) begin
        id_nxt = {id_r[7:0], d};
      end else if ((bc_r == 16'd21) || (bc_r == RES_LAST_BYTE)) begin
        seq_nxt = {seq_r[7:0], d};
      end
      if (do_hdr) begin
        hdr_nxt.hop   = hop_r;
        hdr_nxt.src   = src_r;
        hdr_nxt.dst   = dst_r;
        hdr_nxt.etype = type_r;
        hdr_nxt.ident = id_r;
        hdr_nxt.seq   = {seq_r[7:0], d};
        hdr_full_nxt  = 1'b1;
      end
      if (in_tlast) begin
        bc_nxt   = '0;
        hop_nxt  = '0;
        src_nxt  = '0;
        dst_nxt  = '0;
        type_nxt = '0;
        id_nxt   = '0;
        seq_nxt  = '0;
        sum_nxt  = CK_INIT;
        err_nxt  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r       <= '0;
      hop_r      <= '0;
      src_r      <= '0;
      dst_r      <= '0;
      type_r     <= '0;
      id_r       <= '0;
      seq_r      <= '0;
      sum_r      <= CK_INIT;
      err_r      <= ST_OK;
      hdr_full_r <= 1'b0;
    end else begin
      bc_r       <= bc_nxt;
      hop_r      <= hop_nxt;
      src_r      <= src_nxt;
      dst_r      <= dst_nxt;
      type_r     <= type_nxt;
      id_r       <= id_nxt;
      seq_r      <= seq_nxt;
      sum_r      <= sum_nxt;
      err_r      <= err_nxt;
      hdr_full_r <= hdr_full_nxt;
    end
  end

  // header snapshot, payload only
  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

FILE: design/schc_back.sv
// ----------------------------------------------------------------------------
// schc_back: result sequencer
// Works off the queue head: header burst, payload write, then the patch writes
// or the error status into an output reg, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module schc_back import schc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_entry_t    head,
  input  logic        q_empty,
  input  hdr_t        hdr,
  output logic        pop,
  output logic        hdr_release,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] out_offset, [23:16] out_byte,
                                   // [25:24] status, [31:26] zero
  output logic        out_tuser,   // write_enable
  output logic        out_tlast    // done_res
);

  phase_t      ph_r, ph_nxt, eff;
  logic [5:0]  idx_r, idx_nxt;
  logic        step, last_ph, finish;

  logic        vld_r, vld_nxt;
  logic        we_r, we_nxt;
  logic [15:0] off_r, off_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        done_r, done_nxt;
  status_t     st_r, st_nxt;

  // byte idx of the 48-byte IPv6 + ICMPv6 echo header
  function automatic logic [7:0] hdr_byte(input logic [5:0] i, input hdr_t h);
    logic [7:0] v;
    v = 8'd0;
    case (i) inside
      6'd0:           v = 8'h60;
      6'd6:           v = 8'd58;
      6'd7:           v = h.hop;
      6'd8, 6'd24:    v = 8'hFE;
      6'd9, 6'd25:    v = 8'h80;
      [6'd16:6'd23]:  v = h.src[{~i[2:0], 3'b000} +: 8];
      [6'd32:6'd39]:  v = h.dst[{~i[2:0], 3'b000} +: 8];
      6'd40:          v = h.etype;
      6'd44:          v = h.ident[15:8];
      6'd45:          v = h.ident[7:0];
      6'd46:          v = h.seq[15:8];
      6'd47:          v = h.seq[7:0];
      default:        v = 8'd0;
    endcase
    return v;
  endfunction

  // effective phase: skip parts the head entry does not need
  always_comb begin
    eff = ph_r;
    if ((eff == PH_HDR) && !head.do_hdr) begin
      eff = PH_PAY;
    end
    if ((eff == PH_PAY) && !head.do_pay) begin
      eff = PH_FIN;
    end
  end

  assign step = !q_empty && (!vld_r || out_tready);

  // next state
  always_comb begin
    case (eff)
      PH_HDR:  last_ph = (idx_r == HDR_LAST_IDX);
      PH_PAY:  last_ph = 1'b1;
      PH_FIN:  last_ph = head.fin_ok ? (idx_r == FIN_LAST_IDX) : 1'b1;
      default: last_ph = 1'b1;
    endcase
    finish = last_ph && ((eff == PH_FIN) ||
                         ((eff == PH_PAY) && !head.do_fin) ||
                         ((eff == PH_HDR) && !head.do_pay && !head.do_fin));
    ph_nxt  = ph_r;
    idx_nxt = idx_r;
    if (step) begin
      if (finish) begin
        ph_nxt  = PH_HDR;
        idx_nxt = '0;
      end else if (last_ph) begin
        ph_nxt  = (eff == PH_HDR) ? PH_PAY : PH_FIN;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 6'd1;
      end
    end
  end

  // outputs of the sequencer
  always_comb begin
    pop         = step && finish;
    hdr_release = step && (eff == PH_HDR) && last_ph;
    we_nxt      = 1'b1;
    off_nxt     = '0;
    byte_nxt    = '0;
    done_nxt    = 1'b0;
    st_nxt      = ST_OK;
    case (eff)
      PH_HDR: begin
        off_nxt  = {10'd0, idx_r};
        byte_nxt = hdr_byte(idx_r, hdr);
      end
      PH_PAY: begin
        off_nxt  = head.pay_off;
        byte_nxt = head.pay_byte;
      end
      PH_FIN: begin
        if (head.fin_ok) begin
          case (idx_r[1:0])
            2'd0: begin
              off_nxt  = OFF_LEN_HI;
              byte_nxt = head.fin_len[15:8];
            end
            2'd1: begin
              off_nxt  = OFF_LEN_LO;
              byte_nxt = head.fin_len[7:0];
            end
            2'd2: begin
              off_nxt  = OFF_CK_HI;
              byte_nxt = head.fin_ck[15:8];
            end
            default: begin
              off_nxt  = OFF_CK_LO;
              byte_nxt = head.fin_ck[7:0];
              done_nxt = 1'b1;
            end
          endcase
        end else begin
          we_nxt   = 1'b0;
          done_nxt = 1'b1;
          st_nxt   = head.fin_status;
        end
      end
      default: begin
        we_nxt = 1'b0;
      end
    endcase
    vld_nxt = step ? 1'b1 : (vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_HDR;
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (step) begin
      we_r   <= we_nxt;
      off_r  <= off_nxt;
      byte_r <= byte_nxt;
      done_r <= done_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {6'd0, st_r, byte_r, off_r};
  assign out_tuser  = we_r;
  assign out_tlast  = done_r;

endmodule

FILE: design/schc_icmpv6_echo_decompressor.sv
// ----------------------------------------------------------------------------
// schc_icmpv6_echo_decompressor: streaming SCHC ICMPv6 echo decompressor
// Rebuilds the link-local IPv6 + ICMPv6 echo packet from a compressed byte
// stream, one output byte write per result item, with a final status item.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            contents
//  in_      in   tvalid/tready/tlast  tdata[7:0] data_byte, tlast last_byte
//  out_     out  tvalid/tready/tlast  tdata offset/byte/status, tuser write
//  cfg_     in   APB, pready = 1      reg 0 @ 0x0: out_capacity[15:0]
//
//  Payload and residue bytes are taken one per cycle unless intake stalls;
//  results leave one per cycle, unless stalled, via a registered output stage.
//  The byte that completes the residue causes a 48-byte header burst in the
//  back end; the last byte adds 4 patch results (or 1 status result).
//  A 4-entry queue parts intake from the back end; intake stalls when it is
//  full or when a new residue ends while the previous header is not yet sent.
//  Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module schc_icmpv6_echo_decompressor import schc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] data_byte
  input  logic              in_tlast,    // last_byte
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,   // [15:0] out_offset, [23:16] out_byte,
                                         // [25:24] status, [31:26] zero
  output logic              out_tuser,   // write_enable
  output logic              out_tlast,   // done_res
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [15:0] cap_r, cap_nxt;
  logic        cfg_wr;

  logic        push, pop, q_empty, q_full, hdr_release;
  q_entry_t    push_ent, head;
  hdr_t        hdr;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr && !cfg_paddr[2]) begin
      cap_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, cap_r};

  // intake and classification
  schc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_capacity (cap_r),
    .q_full       (q_full),
    .hdr_release  (hdr_release),
    .push         (push),
    .push_ent     (push_ent),
    .hdr          (hdr)
  );

  // work queue
  schc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // result sequencer
  schc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_empty     (q_empty),
    .hdr         (hdr),
    .pop         (pop),
    .hdr_release (hdr_release),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

FILE: tb/tb_schc_icmpv6_echo_decompressor.sv
// ----------------------------------------------------------------------------
// tb_schc_icmpv6_echo_decompressor: self-checking bench for the decompressor
// Feeds compressed echo packets (well-formed, short, bad type, oversize and
// noise) through the input stream with random gaps and output stalls, and
// predicts every header, payload, patch and status item of the rebuilt
// IPv6 packet. The output capacity register is swept between packet phases.
// ----------------------------------------------------------------------------
module tb_schc_icmpv6_echo_decompressor;
  import schc_pkg::*;

  localparam logic [CFG_AW-1:0] REG_OUT_CAPACITY = '0;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PRINT_LIMIT  = 40;

  // content of the non-type bytes of a built packet
  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } comp_byte_t;

  typedef struct packed {
    logic        we;
    logic [15:0] off;
    logic [7:0]  val;
    logic        done;
    status_t     st;
  } pkt_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] data_byte
  logic        in_tlast = 1'b0;  // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [15:0] out_offset, [23:16] out_byte, [25:24] status
  logic        out_tuser;        // write_enable
  logic        out_tlast;        // done_res
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  schc_icmpv6_echo_decompressor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bench bookkeeping
  comp_byte_t  pending_bytes[$];
  pkt_write_t  expected_writes[$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count = 0;
  int unsigned mismatch_count = 0;
  int          quiet_cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          calm = 1'b0;
  comp_byte_t  next_byte;
  pkt_write_t  want;

  // decompressor state as predicted
  logic [15:0] cap_reg = CAP_RESET;
  int unsigned dc_count;
  int unsigned dc_sum;
  logic [7:0]  dc_hop;
  logic [7:0]  dc_type;
  logic [63:0] dc_src;
  logic [63:0] dc_dst;
  logic [15:0] dc_ident;
  logic [15:0] dc_seq;
  status_t     dc_err;

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    if (mismatch_count < PRINT_LIMIT)
      $display("ERROR result %0d: %s got 0x%0h, expected 0x%0h",
               result_count, what, got, exp_val);
    mismatch_count++;
  endtask

  // ones' complement add, folded after each add
  function automatic int unsigned ones_add(int unsigned s, int unsigned w);
    int unsigned t;
    t = s + (w & 32'hFFFF);
    return (t & 32'hFFFF) + (t >> 16);
  endfunction

  task automatic push_write(logic we, logic [15:0] off, logic [7:0] val, logic done,
                            status_t st);
    pkt_write_t r;
    r.we = we;
    r.off = off;
    r.val = val;
    r.done = done;
    r.st = st;
    expected_writes.push_back(r);
  endtask

  task automatic clear_packet_state;
    dc_count = 0;
    dc_sum = 0;
    dc_hop = '0;
    dc_type = '0;
    dc_src = '0;
    dc_dst = '0;
    dc_ident = '0;
    dc_seq = '0;
    dc_err = ST_OK;
  endtask

  // 48-byte IPv6 + ICMPv6 echo header, length and checksum left zero
  task automatic emit_header;
    logic [7:0]  hb [48];
    int unsigned s;
    int          i;
    for (i = 0; i < 48; i++) hb[i] = 8'h00;
    hb[0] = 8'h60;
    hb[6] = 8'd58;
    hb[7] = dc_hop;
    hb[8] = 8'hFE;
    hb[9] = 8'h80;
    hb[24] = 8'hFE;
    hb[25] = 8'h80;
    for (i = 0; i < 8; i++) begin
      hb[16 + i] = dc_src[63 - 8 * i -: 8];
      hb[32 + i] = dc_dst[63 - 8 * i -: 8];
    end
    hb[40] = dc_type;
    hb[44] = dc_ident[15:8];
    hb[45] = dc_ident[7:0];
    hb[46] = dc_seq[15:8];
    hb[47] = dc_seq[7:0];
    // pseudo-header addresses, next header, then the ICMPv6 header
    s = 0;
    for (i = 8; i < 40; i += 2) s = ones_add(s, {16'd0, hb[i], hb[i + 1]});
    s = ones_add(s, 58);
    for (i = 40; i < 48; i += 2) s = ones_add(s, {16'd0, hb[i], hb[i + 1]});
    dc_sum = s;
    for (i = 0; i < 48; i++) push_write(1'b1, 16'(i), hb[i], 1'b0, ST_OK);
  endtask

  // expected items caused by one accepted compressed byte
  task automatic decompress_byte(logic [7:0] d, logic last);
    int unsigned b;
    int unsigned off;
    int unsigned len;
    int unsigned echo_len;
    int unsigned s;
    int unsigned ck;
    status_t     st;
    b = dc_count;
    if (b >= MAX_PACKET_BYTES) dc_err = ST_TOO_BIG;

    // residue capture
    if (b == 1) dc_hop = d;
    else if (b >= 2 && b <= 9) dc_src = {dc_src[55:0], d};
    else if (b >= 10 && b <= 17) dc_dst = {dc_dst[55:0], d};
    else if (b == 18) dc_type = d;
    else if (b == 19 || b == 20) dc_ident = {dc_ident[7:0], d};
    else if (b == 21 || b == RES_LAST_BYTE) dc_seq = {dc_seq[7:0], d};

    if (b == RES_LAST_BYTE && dc_err == ST_OK) begin
      if (dc_type != ECHO_REQUEST && dc_type != ECHO_REPLY) dc_err = ST_BAD_TYPE;
      else if (cap_reg < HDR_BYTES) dc_err = ST_TOO_BIG;
      else emit_header();
    end else if (b > RES_LAST_BYTE && dc_err == ST_OK) begin
      off = b + 25;
      if (off >= cap_reg) begin
        dc_err = ST_TOO_BIG;
      end else begin
        // even payload index is the high byte of its word
        if (((b - 23) & 1) != 0) dc_sum = ones_add(dc_sum, {24'd0, d});
        else dc_sum = ones_add(dc_sum, {16'd0, d, 8'h00});
        push_write(1'b1, 16'(off), d, 1'b0, ST_OK);
      end
    end

    if (dc_count < 32'hFFFF) dc_count++;

    // end of packet: patch length and checksum, or report status
    if (last) begin
      len = b + 1;
      st = dc_err;
      if (st == ST_OK) begin
        if (len < 23) st = ST_SHORT;
        else if (len + 25 > cap_reg) st = ST_TOO_BIG;
      end
      if (st == ST_OK) begin
        echo_len = (len - 15) & 32'hFFFF;
        s = ones_add(dc_sum, echo_len);
        s = ones_add(s, 0);
        ck = (~s) & 32'hFFFF;
        push_write(1'b1, OFF_LEN_HI, 8'(echo_len >> 8), 1'b0, ST_OK);
        push_write(1'b1, OFF_LEN_LO, 8'(echo_len), 1'b0, ST_OK);
        push_write(1'b1, OFF_CK_HI, 8'(ck >> 8), 1'b0, ST_OK);
        push_write(1'b1, OFF_CK_LO, 8'(ck), 1'b1, ST_OK);
      end else begin
        push_write(1'b0, 16'd0, 8'd0, 1'b1, st);
      end
      clear_packet_state();
    end
  endtask

  // compressed packet: rule byte, residue with the given echo type, payload
  task automatic add_packet(int total_len, logic [7:0] etype, fill_t fill);
    comp_byte_t cb;
    int         k;
    for (k = 0; k < total_len; k++) begin
      case (fill)
        FILL_ZEROS: cb.data = 8'h00;
        FILL_ONES:  cb.data = 8'hFF;
        default:    cb.data = 8'($urandom_range(0, 255));
      endcase
      if (k == 18) cb.data = etype;
      cb.last = (k == total_len - 1);
      pending_bytes.push_back(cb);
      queued_count++;
    end
  endtask

  // mostly well-formed echo packets, some broken ones and noise
  task automatic add_random_packet(int max_pay);
    int         kind;
    int         len;
    logic [7:0] et;
    kind = $urandom_range(0, 9);
    et = ($urandom_range(0, 1) != 0) ? ECHO_REPLY : ECHO_REQUEST;
    if (kind <= 6) begin
      len = 23 + $urandom_range(0, max_pay);
    end else if (kind == 7) begin
      len = 23 + $urandom_range(0, max_pay);
      et = 8'($urandom_range(0, 255));
    end else if (kind == 8) begin
      len = $urandom_range(1, 22);
    end else begin
      len = $urandom_range(1, 60);
      et = 8'($urandom_range(0, 255));
    end
    add_packet(len, et, FILL_RANDOM);
  endtask

  task automatic fill_phase(int n_bytes, int max_pay);
    int unsigned start;
    start = queued_count;
    while (queued_count - start < n_bytes) add_random_packet(max_pay);
  endtask

  // hold until every byte is taken and every item has come out
  task automatic settle;
    while (accepted_count != queued_count || expected_writes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [15:0] cap);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_OUT_CAPACITY;
    cfg_pwdata <= {16'd0, cap};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cap_reg = cap;
  endtask

  // input driver: one item per handshake, random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decompress_byte(in_tdata, in_tlast);
        accepted_count++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_byte.data;
          in_tlast <= next_byte.last;
          if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: field checks against the oldest expected item
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("item with nothing expected, offset", out_tdata[15:0], 0);
        end else begin
          want = expected_writes.pop_front();
          if (out_tuser !== want.we)
            report_mismatch("write_enable", out_tuser, want.we);
          if (out_tdata[15:0] !== want.off)
            report_mismatch("out_offset", out_tdata[15:0], want.off);
          if (out_tdata[23:16] !== want.val)
            report_mismatch("out_byte", out_tdata[23:16], want.val);
          if (out_tlast !== want.done)
            report_mismatch("done_res", out_tlast, want.done);
          if (out_tdata[25:24] !== want.st)
            report_mismatch("status", out_tdata[25:24], want.st);
        end
        result_count++;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) out_gap = $urandom_range(1, 9);
      end
    end
  end

  // watchdog: too long with no handshake on either stream
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // stimulus phases
  initial begin
    clear_packet_state();
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: lone rule byte, then a minimal packet with all-ones fields
    add_packet(1, 8'hFF, FILL_ONES);
    add_packet(23, ECHO_REPLY, FILL_ONES);
    fill_phase(90, 40);
    settle();

    // no room at all: header never fits
    set_capacity(16'd0);
    fill_phase(40, 10);
    settle();

    // room for exactly the header and nothing more
    set_capacity(HDR_BYTES);
    add_packet(23, ECHO_REQUEST, FILL_ZEROS);
    fill_phase(30, 4);
    settle();

    // tight buffer: payload overflows part way
    set_capacity(16'd61);
    fill_phase(60, 20);
    settle();

    // widest buffer: long payloads
    set_capacity(16'hFFFF);
    fill_phase(40, 60);
    settle();

    // back to the reset value, streams at full rate
    calm = 1'b1;
    set_capacity(CAP_RESET);
    fill_phase(60, 40);
    settle();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
